// ===== hdl/sla_pkg.sv =====
`default_nettype none
package sla_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SET    = 3'd1,
    OP_FLASH  = 3'd2,
    OP_CMD    = 3'd3,
    OP_COLOUR = 3'd4,
    OP_PULSE  = 3'd5,
    OP_STOP   = 3'd6,
    OP_OFF    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_FLASH = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_PULSE = 2'd3
  } mode_t;

  // status codes
  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_READY    = 4'd1;
  localparam logic [3:0] ST_MOVING   = 4'd2;
  localparam logic [3:0] ST_IDLE     = 4'd3;
  localparam logic [3:0] ST_COMMAND  = 4'd4;
  localparam logic [3:0] ST_DRV_OFF  = 4'd5;
  localparam logic [3:0] ST_WARNING  = 4'd6;
  localparam logic [3:0] ST_ERROR    = 4'd7;
  localparam logic [3:0] ST_STALL    = 4'd8;
  localparam logic [3:0] ST_REBOOT   = 4'd9;

  // driver types and accel profiles
  localparam logic [1:0] DRV_GREEN = 2'd0;
  localparam logic [1:0] DRV_CYAN  = 2'd1;
  localparam logic [1:0] DRV_BLUE  = 2'd2;
  localparam logic [1:0] PROF_TRAP  = 2'd1;
  localparam logic [1:0] PROF_SCURV = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_DRIVER     = 2'd1;
  localparam logic [1:0] REG_PROFILE    = 2'd2;

  localparam logic [15:0] IV_MOVING  = 16'd80;
  localparam logic [15:0] IV_STALL   = 16'd100;
  localparam logic [15:0] IV_WARNING = 16'd500;
  localparam logic [15:0] IV_DEFAULT = 16'd150;
  localparam logic [15:0] PULSE_MS   = 16'd50;
  localparam logic [15:0] CMD_FLASH_MS = 16'd100;
  localparam logic [7:0]  PULSE_STEP = 8'd5;
  localparam logic [7:0]  PULSE_MAX  = 8'd100;
  localparam logic [7:0]  PULSE_MIN  = 8'd10;
  localparam logic [6:0]  PULSE_START = 7'd50;
  localparam logic [8:0]  TINT       = 9'd50;
  // floor(p/100) == (p*5243)>>19 for p <= 25500
  localparam logic [27:0] RECIP_100  = 28'd5243;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  status;
    rgb_t        colour;
    logic [15:0] duration_ms;
  } item_t;

  typedef struct packed {
    rgb_t colour;
    logic last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;  // 0, 1 or 2 results this cycle
    res_t       a;
    res_t       b;
  } push_t;

  localparam rgb_t BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0};

  // floor(x/5) for x < 1024
  function automatic logic [7:0] div5(input logic [9:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:10];
  endfunction

  // floor(x/3) for 8-bit x
  function automatic logic [7:0] div3(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return {1'b0, p[15:9]};
  endfunction

  function automatic logic [7:0] add_tint(input logic [7:0] x);
    logic [8:0] s;
    s = {1'b0, x} + TINT;
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic rgb_t driver_colour(input logic [7:0] v, input logic [1:0] drv,
                                         input logic [1:0] prof);
    rgb_t c;
    case (drv)
      DRV_GREEN: c = '{r: 8'd0, g: v, b: 8'd0};
      DRV_CYAN:  c = '{r: 8'd0, g: v, b: div5({v, 2'b00})};
      DRV_BLUE:  c = '{r: 8'd0, g: div5({1'b0, v, 1'b0}), b: v};
      default:   c = '{r: v, g: v, b: v};
    endcase
    if (prof == PROF_TRAP) begin
      c.r = add_tint(c.r);
    end else if (prof == PROF_SCURV) begin
      c.b = add_tint(c.b);
    end
    return c;
  endfunction

  function automatic rgb_t status_colour(input logic [3:0] s, input logic [7:0] v,
                                         input logic [1:0] drv, input logic [1:0] prof);
    rgb_t c;
    case (s)
      ST_INIT:                       c = '{r: 8'd0, g: 8'd0, b: v};
      ST_READY, ST_MOVING, ST_IDLE:  c = driver_colour(v, drv, prof);
      ST_COMMAND, ST_WARNING:        c = '{r: v, g: {1'b0, v[7:1]}, b: 8'd0};
      ST_DRV_OFF, ST_REBOOT:         c = BLACK;
      ST_ERROR, ST_STALL:            c = '{r: v, g: 8'd0, b: 8'd0};
      default:                       c = '{r: v, g: v, b: v};
    endcase
    return c;
  endfunction

  function automatic logic [15:0] blink_interval(input logic [3:0] s);
    logic [15:0] iv;
    case (s)
      ST_MOVING:  iv = IV_MOVING;
      ST_STALL:   iv = IV_STALL;
      ST_WARNING: iv = IV_WARNING;
      default:    iv = IV_DEFAULT;
    endcase
    return iv;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sla_front.sv =====
`default_nettype none
module sla_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [47:0]   s_axis_tdata,
  input  wire logic [2:0]    s_axis_tuser,
  output logic               item_valid,
  output sla_pkg::item_t     item,
  input  wire logic          item_take
);
  import sla_pkg::*;

  // two-entry item queue
  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       accept;
  item_t      decoded;

  always_comb begin
    decoded.op          = op_t'(s_axis_tuser);
    decoded.status      = s_axis_tdata[3:0];
    decoded.colour.r    = s_axis_tdata[11:4];
    decoded.colour.g    = s_axis_tdata[19:12];
    decoded.colour.b    = s_axis_tdata[27:20];
    decoded.duration_ms = s_axis_tdata[43:28];
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (cnt != 2'd0);
  assign item          = q[rp];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (accept) begin
        wp <= ~wp;
      end
      if (item_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, item_take};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sla_back.sv =====
`default_nettype none
module sla_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    brightness,
  input  wire logic [1:0]    driver_type,
  input  wire logic [1:0]    accel_profile,
  input  wire logic          item_valid,
  input  wire sla_pkg::item_t item,
  output logic               item_take,
  input  wire logic          room2,
  output sla_pkg::push_t     push
);
  import sla_pkg::*;

  typedef enum logic [3:0] {
    S_EXEC = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_SHOW = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [3:0]  cur_status, cur_status_next;
  rgb_t        base, base_next;
  rgb_t        shown;
  mode_t       mode, mode_next;
  logic [15:0] flash_rem, flash_rem_next;
  logic [15:0] ms, ms_next;
  logic        blink_on, blink_on_next;
  logic [6:0]  plevel, plevel_next;
  logic        prising, prising_next;
  logic [3:0]  q_status, q_status_next;
  logic        q_valid, q_valid_next;

  logic [14:0] prod_r, prod_g, prod_b;
  rgb_t        scaled;

  logic        c1_en, c2_en;
  rgb_t        c1, c2;
  logic        pulse_go;
  logic        emit;
  logic        e1, e2;
  rgb_t        s1, shown_final;

  // scratch for the exec step
  logic [15:0] ms_inc;
  logic [15:0] fr;
  logic        ss_do;
  logic [3:0]  ss_s;
  rgb_t        sc;
  logic [7:0]  lv;
  logic [27:0] qr, qg, qb;

  assign ms_inc = (ms == 16'hFFFF) ? ms : ms + 16'd1;

  always_comb begin
    cur_status_next = cur_status;
    base_next       = base;
    mode_next       = mode;
    flash_rem_next  = flash_rem;
    ms_next         = ms;
    blink_on_next   = blink_on;
    plevel_next     = plevel;
    prising_next    = prising;
    q_status_next   = q_status;
    q_valid_next    = q_valid;
    c1_en    = 1'b0;
    c1       = BLACK;
    c2_en    = 1'b0;
    c2       = base;
    pulse_go = 1'b0;
    ss_do    = 1'b0;
    ss_s     = item.status;
    fr       = 16'd0;
    sc       = BLACK;
    lv       = 8'd0;
    case (item.op)
      OP_TICK: begin
        ms_next = ms_inc;
        case (mode)
          MODE_FLASH: begin
            fr = (flash_rem != 16'd0) ? flash_rem - 16'd1 : 16'd0;
            flash_rem_next = fr;
            if (fr == 16'd0) begin
              mode_next = MODE_NONE;
              if (q_valid) begin
                q_valid_next = 1'b0;
                ss_do = 1'b1;
                ss_s  = q_status;
              end else begin
                sc = status_colour(cur_status, brightness, driver_type, accel_profile);
                base_next = sc;
                c2_en = 1'b1;
                c2    = sc;
              end
            end
          end
          MODE_BLINK: begin
            blink_on_next = blink_on;
            if (ms_inc >= blink_interval(cur_status)) begin
              blink_on_next = ~blink_on;
              ms_next = 16'd0;
            end
            c2_en = 1'b1;
            c2    = blink_on_next ? base : BLACK;
          end
          MODE_PULSE: begin
            if (ms_inc >= PULSE_MS) begin
              lv = prising ? {1'b0, plevel} + PULSE_STEP
                 : (({1'b0, plevel} >= PULSE_STEP) ? {1'b0, plevel} - PULSE_STEP : 8'd0);
              if (lv >= PULSE_MAX) begin
                lv = PULSE_MAX;
                prising_next = 1'b0;
              end else if (lv <= PULSE_MIN) begin
                lv = PULSE_MIN;
                prising_next = 1'b1;
              end
              plevel_next = lv[6:0];
              ms_next  = 16'd0;
              pulse_go = 1'b1;
            end
          end
          default: begin
            c2_en = 1'b1;
            c2    = base;
          end
        endcase
      end
      OP_SET: begin
        ss_do = 1'b1;
      end
      OP_FLASH: begin
        flash_rem_next = item.duration_ms;
        mode_next = MODE_FLASH;
        c2_en = 1'b1;
        c2    = item.colour;
      end
      OP_CMD: begin
        flash_rem_next = CMD_FLASH_MS;
        mode_next = MODE_FLASH;
        c2_en = 1'b1;
        c2    = '{r: brightness, g: div3(brightness), b: 8'd0};
      end
      OP_COLOUR: begin
        base_next = item.colour;
        mode_next = MODE_NONE;
        c2_en = 1'b1;
        c2    = item.colour;
      end
      OP_PULSE: begin
        mode_next    = MODE_PULSE;
        plevel_next  = PULSE_START;
        prising_next = 1'b1;
        ms_next      = 16'd0;
      end
      OP_STOP: begin
        mode_next = MODE_NONE;
        c2_en = 1'b1;
        c2    = base;
      end
      default: begin
        mode_next = MODE_NONE;
        c2_en = 1'b1;
        c2    = BLACK;
      end
    endcase

    // set status: queued while a flash runs
    if (ss_do) begin
      if (mode_next == MODE_FLASH) begin
        q_status_next = ss_s;
        q_valid_next  = 1'b1;
      end else begin
        sc = status_colour(ss_s, brightness, driver_type, accel_profile);
        cur_status_next = ss_s;
        base_next = sc;
        if (ss_s == ST_MOVING || ss_s == ST_WARNING || ss_s == ST_STALL) begin
          mode_next     = MODE_BLINK;
          blink_on_next = 1'b0;
          ms_next       = 16'd0;
          c1_en = 1'b1;
          c1    = BLACK;
        end else if (ss_s == ST_IDLE) begin
          mode_next    = MODE_PULSE;
          plevel_next  = PULSE_START;
          prising_next = 1'b1;
          ms_next      = 16'd0;
        end else begin
          mode_next = MODE_NONE;
        end
        c2_en = 1'b1;
        c2    = sc;
      end
    end

    // pulse output is shown from the scaled colour
    if (state == S_SHOW) begin
      c1_en = 1'b0;
      c2_en = 1'b1;
      c2    = scaled;
    end
  end

  // write-on-change filter over up to two candidate colours
  always_comb begin
    e1 = c1_en && (c1 != shown);
    s1 = e1 ? c1 : shown;
    e2 = c2_en && (c2 != s1);
    shown_final = e2 ? c2 : s1;
    push.cnt = {1'b0, e1} + {1'b0, e2};
    push.a.colour = e1 ? c1 : c2;
    push.a.last   = e1 ? !e2 : 1'b1;
    push.b.colour = c2;
    push.b.last   = 1'b1;
    if (!emit) begin
      push.cnt = 2'd0;
    end
  end

  // a pulse step keeps its item at the queue head until the scaled colour is out
  assign item_take = ((state == S_EXEC) && item_valid && room2 && !pulse_go) ||
                     ((state == S_SHOW) && room2);
  assign emit      = item_take || ((state == S_SHOW) && room2);

  always_comb begin
    state_next = state;
    case (state)
      S_EXEC: begin
        if (item_valid && room2 && pulse_go) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_DIV;
      S_DIV:  state_next = S_SHOW;
      S_SHOW: begin
        if (room2) begin
          state_next = S_EXEC;
        end
      end
      default: state_next = S_EXEC;
    endcase
  end

  // pulse scaling datapath: product, then reciprocal of 100
  assign qr = 28'(prod_r) * RECIP_100;
  assign qg = 28'(prod_g) * RECIP_100;
  assign qb = 28'(prod_b) * RECIP_100;

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod_r <= 15'(base.r) * 15'(plevel);
      prod_g <= 15'(base.g) * 15'(plevel);
      prod_b <= 15'(base.b) * 15'(plevel);
    end
    if (state == S_DIV) begin
      scaled <= '{r: qr[26:19], g: qg[26:19], b: qb[26:19]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_EXEC;
      cur_status <= ST_INIT;
      base       <= '{r: 8'd0, g: 8'd0, b: 8'd50};
      shown      <= BLACK;
      mode       <= MODE_NONE;
      flash_rem  <= 16'd0;
      ms         <= 16'd0;
      blink_on   <= 1'b0;
      plevel     <= PULSE_START;
      prising    <= 1'b1;
      q_status   <= ST_READY;
      q_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        shown <= shown_final;
      end
      // state update happens when the item is executed, pulse step included
      if ((state == S_EXEC) && item_valid && room2) begin
        cur_status <= cur_status_next;
        base       <= base_next;
        mode       <= mode_next;
        flash_rem  <= flash_rem_next;
        ms         <= ms_next;
        blink_on   <= blink_on_next;
        plevel     <= plevel_next;
        prising    <= prising_next;
        q_status   <= q_status_next;
        q_valid    <= q_valid_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sla_outq.sv =====
`default_nettype none
module sla_outq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sla_pkg::push_t push,
  output logic               room2,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [23:0]        m_axis_tdata,
  output logic               m_axis_tlast
);
  import sla_pkg::*;

  // four-entry result queue, takes up to two results a cycle
  res_t       mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       pop;
  res_t       head;

  assign room2         = (cnt <= 3'd2);
  assign m_axis_tvalid = (cnt != 3'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = mem[rp];
  assign m_axis_tdata  = {head.colour.b, head.colour.g, head.colour.r};
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem[wp + 2'd1] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      wp  <= wp + push.cnt;
      if (pop) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + {1'b0, push.cnt} - {2'b00, pop};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/status_led_animator.sv =====
`default_nettype none
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: operation; tdata: status..duration_ms
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: red, green, blue; tlast: last_write
// cfg       in   cfg_we (no wait)              cfg_index, cfg_wdata
//
// Cycles: the front takes an item every cycle while its 2-entry queue has room.
// The back executes one item per cycle while the result queue has room; a pulse step
// (tick that moves the pulse level) holds its item for multiply and reciprocal-of-100 stages.
// Back executes only with two free slots in the 4-entry result queue, so a stall
// on m_axis backs up through the result queue, then the item queue.
// Reset: synchronous; no clearing pass.
module status_led_animator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] status, [11:4] red_in, [19:12] green_in, [27:20] blue_in,
  // [43:28] duration_ms, [47:44] zero
  input  wire logic [47:0] s_axis_tdata,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import sla_pkg::*;

  logic [7:0] brightness;
  logic [1:0] driver_type;
  logic [1:0] accel_profile;

  logic  item_valid;
  item_t item;
  logic  item_take;
  logic  room2;
  push_t push;

  // config registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= 8'd50;
      driver_type   <= 2'd3;
      accel_profile <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness    <= cfg_wdata;
        REG_DRIVER:     driver_type   <= cfg_wdata[1:0];
        REG_PROFILE:    accel_profile <= cfg_wdata[1:0];
        default:        ;
      endcase
    end
  end

  sla_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  sla_back u_back (
    .clk           (clk),
    .rst           (rst),
    .brightness    (brightness),
    .driver_type   (driver_type),
    .accel_profile (accel_profile),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .room2         (room2),
    .push          (push)
  );

  sla_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .room2         (room2),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // back never dequeues from an empty item queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    item_take |-> item_valid)
    else $error("item taken from empty queue");

  // results are pushed only when the result queue has room for two
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room2)
    else $error("result push without room");

  // a pair of results ends on the second one
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd2) |-> (!push.a.last && push.b.last))
    else $error("bad last marking on result pair");

  // result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
